// ===== hdl/pidtc_pkg.sv =====
// shared types and constants for the pid temperature controller
`timescale 1ns / 1ps
package pidtc_pkg;

  // field widths
  localparam int TempW    = 16;
  localparam int GainW    = 24;
  localparam int ErrW     = TempW + 1;
  localparam int DiffW    = ErrW + 1;
  localparam int PTermW   = ErrW + GainW - 8;
  localparam int DTermW   = DiffW + GainW - 8;
  localparam int IntegW   = 18;
  localparam int SumW     = PTermW + 1;
  localparam int RespW    = 36;
  localparam int DriveW   = 32;
  localparam int ModeW    = 2;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 24;

  // integral clamp bound, 1.0 in q16.16
  localparam int OneQ16 = 65536;

  // drive saturation bounds
  localparam logic [DriveW-1:0] DriveMax = 32'h7FFF_FFFF;
  localparam logic [DriveW-1:0] DriveMin = 32'h8000_0000;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegTarget   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegPGain    = 3'd1;
  localparam logic [CfgAddrW-1:0] RegIGain    = 3'd2;
  localparam logic [CfgAddrW-1:0] RegDGain    = 3'd3;
  localparam logic [CfgAddrW-1:0] RegLoopMode = 3'd4;

  typedef enum logic [ModeW-1:0] {
    ModePid  = 2'd0,
    ModePi   = 2'd1,
    ModeP    = 2'd2,
    ModeRsvd = 2'd3
  } loop_mode_e;

  // floored q16.16 terms of one item
  typedef struct packed {
    logic signed [PTermW-1:0] p;
    logic signed [PTermW-1:0] i;
    logic signed [DTermW-1:0] d;
  } terms_t;

endpackage

// ===== hdl/pidtc_products.sv =====
// error forming and the three gain products, floored to q16.16
`timescale 1ns / 1ps
module pidtc_products
  import pidtc_pkg::*;
(
  input  logic signed [TempW-1:0] temp_i,
  input  logic signed [TempW-1:0] prev_temp_i,
  input  logic signed [TempW-1:0] target_i,
  input  logic signed [GainW-1:0] p_gain_i,
  input  logic signed [GainW-1:0] i_gain_i,
  input  logic signed [GainW-1:0] d_gain_i,
  output terms_t                  terms_o
);

  logic signed [ErrW-1:0]               e_new;
  logic signed [ErrW-1:0]               e_old;
  logic signed [DiffW-1:0]              e_diff;
  logic signed [ErrW+GainW-1:0]         prod_p;
  logic signed [ErrW+GainW-1:0]         prod_i;
  logic signed [DiffW+GainW-1:0]        prod_d;

  assign e_new  = {temp_i[TempW-1], temp_i} - {target_i[TempW-1], target_i};
  assign e_old  = {prev_temp_i[TempW-1], prev_temp_i} - {target_i[TempW-1], target_i};
  assign e_diff = {e_new[ErrW-1], e_new} - {e_old[ErrW-1], e_old};

  assign prod_p = e_new * p_gain_i;
  assign prod_i = e_new * i_gain_i;
  assign prod_d = e_diff * d_gain_i;

  // dropping the low 8 bits floors toward minus infinity
  assign terms_o.p = prod_p[ErrW+GainW-1:8];
  assign terms_o.i = prod_i[ErrW+GainW-1:8];
  assign terms_o.d = prod_d[DiffW+GainW-1:8];

endmodule

// ===== hdl/pidtc_integ.sv =====
// integral register, mode select and drive saturation
`timescale 1ns / 1ps
module pidtc_integ
  import pidtc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upd_i,
  input  loop_mode_e               mode_i,
  input  terms_t                   terms_i,
  output logic signed [DriveW-1:0] drive_o,
  output logic                     sat_o,
  output logic signed [IntegW-1:0] integ_o
);

  localparam logic signed [SumW-1:0]   SumPosOne   = SumW'(OneQ16);
  localparam logic signed [SumW-1:0]   SumNegOne   = -SumPosOne;
  localparam logic signed [IntegW-1:0] IntegPosOne = IntegW'(OneQ16);
  localparam logic signed [IntegW-1:0] IntegNegOne = -IntegPosOne;

  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [SumW-1:0]   s_sum;
  logic signed [IntegW-1:0] s_clamp;
  logic signed [RespW-1:0]  p_ext, s_ext, d_ext, resp;
  logic                     sat_hi, sat_lo;

  assign s_sum = {{(SumW-IntegW){integ_q[IntegW-1]}}, integ_q}
               + {{(SumW-PTermW){terms_i.i[PTermW-1]}}, terms_i.i};

  always_comb begin
    if (s_sum >= SumPosOne) begin
      s_clamp = IntegPosOne;
    end else if (s_sum <= SumNegOne) begin
      s_clamp = IntegNegOne;
    end else begin
      s_clamp = s_sum[IntegW-1:0];
    end
  end

  assign p_ext = {{(RespW-PTermW){terms_i.p[PTermW-1]}}, terms_i.p};
  assign s_ext = {{(RespW-SumW){s_sum[SumW-1]}}, s_sum};
  assign d_ext = {{(RespW-DTermW){terms_i.d[DTermW-1]}}, terms_i.d};

  always_comb begin
    case (mode_i)
      ModeP: begin
        integ_d = '0;
        resp    = p_ext;
      end
      ModePi: begin
        integ_d = s_clamp;
        resp    = p_ext + s_ext;
      end
      ModePid: begin
        integ_d = s_clamp;
        resp    = p_ext + s_ext + d_ext;
      end
      ModeRsvd: begin
        integ_d = s_clamp;
        resp    = '0;
      end
      default: begin
        integ_d = integ_q;
        resp    = '0;
      end
    endcase
  end

  // out of 32-bit range when bits 34 down to 31 do not all match the sign bit 35
  assign sat_hi = !resp[RespW-1] && (resp[RespW-2:DriveW-1] != '0);
  assign sat_lo = resp[RespW-1] && (resp[RespW-2:DriveW-1] != '1);

  always_comb begin
    if (sat_hi) begin
      drive_o = DriveMax;
    end else if (sat_lo) begin
      drive_o = DriveMin;
    end else begin
      drive_o = resp[DriveW-1:0];
    end
  end

  assign sat_o   = sat_hi | sat_lo;
  assign integ_o = integ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (upd_i) begin
      integ_q <= integ_d;
    end
  end

endmodule

// ===== hdl/pid_temperature_controller.sv =====
// top level of the pid temperature controller with clamped integral
`timescale 1ns / 1ps
// throughput: one item per cycle while the output is not stalled; the integral add and clamp are combinational
// stages: input register, product register (three multiplies), output register
// reset (async, active low) clears the config registers, the integral and all valid bits
module pid_temperature_controller
  import pidtc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgAddrW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  // input item channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [TempW-1:0]    temperature_i,
  input  logic signed [TempW-1:0]    previous_temperature_i,
  // result item channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DriveW-1:0]   drive_o,
  output logic                       saturated_o
);

  // config registers
  logic signed [TempW-1:0] target_q;
  logic signed [GainW-1:0] p_gain_q, i_gain_q, d_gain_q;
  loop_mode_e              loop_mode_q;

  // pipeline registers
  logic                    v1_q, v2_q, out_v_q;
  logic signed [TempW-1:0] temp1_q, prev1_q;
  terms_t                  terms_d, terms2_q;
  logic signed [DriveW-1:0] drive_d, drive_q;
  logic                    sat_d, sat_q;
  logic signed [IntegW-1:0] integ;

  // per-stage advance: a stage moves when empty or when the next one moves
  logic en_out, en2, en1, in_acc, integ_upd;

  assign en_out    = !out_v_q || !out_stall_i;
  assign en2       = !v2_q || en_out;
  assign en1       = !v1_q || en2;
  assign in_acc    = in_valid_i && en1;
  assign integ_upd = v2_q && en_out;

  assign in_stall_o  = !en1;
  assign cfg_ready_o = 1'b1;

  // config writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      p_gain_q    <= '0;
      i_gain_q    <= '0;
      d_gain_q    <= '0;
      loop_mode_q <= ModePid;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegTarget:   target_q    <= cfg_data_i[TempW-1:0];
        RegPGain:    p_gain_q    <= cfg_data_i[GainW-1:0];
        RegIGain:    i_gain_q    <= cfg_data_i[GainW-1:0];
        RegDGain:    d_gain_q    <= cfg_data_i[GainW-1:0];
        RegLoopMode: loop_mode_q <= loop_mode_e'(cfg_data_i[ModeW-1:0]);
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      temp1_q <= temperature_i;
      prev1_q <= previous_temperature_i;
    end
  end

  // errors and gain products
  pidtc_products u_products (
    .temp_i      (temp1_q),
    .prev_temp_i (prev1_q),
    .target_i    (target_q),
    .p_gain_i    (p_gain_q),
    .i_gain_i    (i_gain_q),
    .d_gain_i    (d_gain_q),
    .terms_o     (terms_d)
  );

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      terms2_q <= terms_d;
    end
  end

  // integral update and response; the integral moves only when the item leaves
  pidtc_integ u_integ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (integ_upd),
    .mode_i  (loop_mode_q),
    .terms_i (terms2_q),
    .drive_o (drive_d),
    .sat_o   (sat_d),
    .integ_o (integ)
  );

  // output register, holds while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (integ_upd) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

  // integral never leaves plus or minus 1.0
  a_integ_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ <= IntegW'(OneQ16)) && (integ >= -IntegW'(OneQ16)))
    else $error("integral out of clamp range");

  // a saturated item carries one of the two bounds
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> ((drive_o == DriveMax) || (drive_o == DriveMin)))
    else $error("saturated flag without a bound value");

  // p-only mode leaves the integral cleared
  a_p_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_upd && (loop_mode_q == ModeP)) |=> (integ == '0))
    else $error("integral not cleared in p mode");

  // reserved mode answers zero
  a_rsvd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (loop_mode_q == ModeRsvd)) |-> ((drive_o == '0) && !saturated_o))
    else $error("reserved mode gave nonzero drive");

  // input stalls only when the first stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q)
    else $error("input stalled with empty input stage");

endmodule
